[sv/lkvc_pkg.sv]
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants for the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int CSR_BITS   = 5;

   localparam logic [CSR_BITS-1:0] CSR_CAP_RESET = 5'd16;

   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_PUT = 1'b1;

   typedef struct packed {
      logic                  req_type;
      logic [KEY_BITS-1:0]   lookup_key;
      logic [VALUE_BITS-1:0] put_value;
   } lkvc_req_type;

   typedef struct packed {
      logic                  hit;
      logic [VALUE_BITS-1:0] read_value;
      logic                  evicted;
      logic [KEY_BITS-1:0]   evicted_key;
      logic [VALUE_BITS-1:0] evicted_value;
   } lkvc_rsp_type;

endpackage

[sv/lkvc_slots.sv]
// ----------------------------------------------------------------------------
// lkvc_slots
// Entry array: parallel key match, age ranks, victim pick and slot update.
// ----------------------------------------------------------------------------
module lkvc_slots #(
   parameter int ENTRIES = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             fire,
   input  lkvc_pkg::lkvc_req_type           req,
   input  logic [lkvc_pkg::CSR_BITS-1:0]    cap,
   output lkvc_pkg::lkvc_rsp_type           rsp
);
   import lkvc_pkg::*;

   localparam int CW   = $clog2(ENTRIES + 1);
   localparam int AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CMPW = (CW > CSR_BITS) ? CW : CSR_BITS;

   logic                  valid_ff [ENTRIES];
   logic [AW-1:0]         age_ff   [ENTRIES];
   logic [KEY_BITS-1:0]   key_ff   [ENTRIES];
   logic [VALUE_BITS-1:0] value_ff [ENTRIES];
   logic [CW-1:0]         fill_ff;

   logic                  valid_in [ENTRIES];
   logic [AW-1:0]         age_in   [ENTRIES];
   logic [KEY_BITS-1:0]   key_in   [ENTRIES];
   logic [VALUE_BITS-1:0] value_in [ENTRIES];
   logic [CW-1:0]         fill_in;

   logic          match_found, free_found;
   logic [AW-1:0] match_idx, free_idx, old_idx, tgt, sel;
   logic [CW-1:0] thr, fill_m1;
   logic [CMPW-1:0] cap_lo;
   logic          is_put, can_fill, do_fill, do_evict, upd;

   always_comb begin
      match_found = 1'b0;
      free_found  = 1'b0;
      match_idx   = '0;
      free_idx    = '0;
      old_idx     = '0;
      fill_m1     = fill_ff - CW'(1);
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && key_ff[i] == req.lookup_key) begin
            match_found = 1'b1;
            match_idx   = AW'(i);
         end
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = AW'(i);
         end
         if (valid_ff[i] && CW'(age_ff[i]) == fill_m1) begin
            old_idx = AW'(i);
         end
      end

      is_put   = (req.req_type == REQ_PUT);
      cap_lo   = (cap == '0) ? CMPW'(1) : CMPW'(cap);
      can_fill = (CMPW'(fill_ff) < cap_lo) && (CMPW'(fill_ff) < CMPW'(ENTRIES)) && free_found;
      do_fill  = !match_found && is_put && can_fill;
      do_evict = !match_found && is_put && !can_fill;
      upd      = fire && (match_found || is_put);

      sel = match_found ? match_idx : old_idx;
      tgt = match_found ? match_idx : (do_fill ? free_idx : old_idx);
      thr = match_found ? CW'(age_ff[match_idx]) : fill_ff;

      rsp.hit           = match_found;
      rsp.read_value    = (match_found && !is_put) ? value_ff[sel] : '0;
      rsp.evicted       = do_evict;
      rsp.evicted_key   = do_evict ? key_ff[sel] : '0;
      rsp.evicted_value = do_evict ? value_ff[sel] : '0;

      fill_in = (fire && do_fill) ? fill_ff + CW'(1) : fill_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         valid_in[i] = valid_ff[i];
         age_in[i]   = age_ff[i];
         key_in[i]   = key_ff[i];
         value_in[i] = value_ff[i];
         if (upd) begin
            if (AW'(i) == tgt) begin
               valid_in[i] = 1'b1;
               age_in[i]   = '0;
               if (is_put) begin
                  value_in[i] = req.put_value;
               end
               if (!match_found) begin
                  key_in[i] = req.lookup_key;
               end
            end else if (valid_ff[i] && CW'(age_ff[i]) < thr) begin
               age_in[i] = age_ff[i] + AW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
            age_ff[i]   <= '0;
         end
      end else begin
         fill_ff <= fill_in;
         for (int i = 0; i < ENTRIES; i++) begin
            valid_ff[i] <= valid_in[i];
            age_ff[i]   <= age_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         key_ff[i]   <= key_in[i];
         value_ff[i] <= value_in[i];
      end
   end

endmodule

[sv/lru_key_value_cache.sv]
// Response path: an accepted request is held in the input register, then lookup
//   and update write the response register.
// Throughput: 1 request per cycle while rsp_stall is low; the entry compare and
//   age update are one combinational pass over all entries.
// Reset: synchronous; empties the cache and sets capacity to 16.
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
   parameter int ENTRIES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  lkvc_pkg::lkvc_req_type        req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output lkvc_pkg::lkvc_rsp_type        rsp_data,
   input  logic                          csr_write_enable,
   input  logic [lkvc_pkg::CSR_BITS-1:0] csr_write_data
);
   import lkvc_pkg::*;

   logic                in_v_ff, in_v_in;
   lkvc_req_type        in_ff;
   logic                out_v_ff, out_v_in;
   lkvc_rsp_type        out_ff;
   logic [CSR_BITS-1:0] cap_ff, cap_in;
   lkvc_rsp_type        result;
   logic                adv, accept;

   assign adv       = in_v_ff && (!out_v_ff || !rsp_stall);
   assign req_stall = in_v_ff && !adv;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      in_v_in  = accept ? 1'b1 : (adv ? 1'b0 : in_v_ff);
      out_v_in = adv ? 1'b1 : (out_v_ff && rsp_stall);
      cap_in   = csr_write_enable ? csr_write_data : cap_ff;
   end

   lkvc_slots #(
      .ENTRIES (ENTRIES)
   ) u_slots (
      .clock (clock),
      .reset (reset),
      .fire  (adv),
      .req   (in_ff),
      .cap   (cap_ff),
      .rsp   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         cap_ff   <= CSR_CAP_RESET;
      end else begin
         in_v_ff  <= in_v_in;
         out_v_ff <= out_v_in;
         cap_ff   <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_data;
      end
      if (adv) begin
         out_ff <= result;
      end
   end

endmodule

[sv/lkvc_checker.sv]
// ----------------------------------------------------------------------------
// lkvc_checker
// Port-level checks for the LRU key/value cache.
// ----------------------------------------------------------------------------
module lkvc_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input lkvc_pkg::lkvc_rsp_type rsp_data
);
   import lkvc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   a_evict_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.evicted |-> !rsp_data.hit)
      else $error("eviction reported on a hit");

   a_evict_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.evicted |->
         rsp_data.evicted_key == '0 && rsp_data.evicted_value == '0)
      else $error("evicted word nonzero without eviction");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.read_value == '0)
      else $error("read value nonzero on miss");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[bench/lru_key_value_cache_checker.sv]
// ----------------------------------------------------------------------------
// lru_key_value_cache_checker
// Watches the request, response and CSR ports of the LRU key/value cache,
// keeps its own copy of the cache contents and recency order, and compares
// every response word field by field against the predicted one.
// ----------------------------------------------------------------------------
module lru_key_value_cache_checker #(
   parameter int ENTRIES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  lkvc_pkg::lkvc_req_type        req_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  lkvc_pkg::lkvc_rsp_type        rsp_data,
   input  logic                          csr_write_enable,
   input  logic [lkvc_pkg::CSR_BITS-1:0] csr_write_data,
   output int                            fail_count,
   output int                            pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import lkvc_pkg::*;

   logic                  slot_used   [ENTRIES];
   logic [KEY_BITS-1:0]   slot_tag    [ENTRIES];
   logic [VALUE_BITS-1:0] slot_handle [ENTRIES];
   int                    slot_rank   [ENTRIES];
   int                    fill_level;
   logic [CSR_BITS-1:0]   cap_setting;
   lkvc_rsp_type          lookup_results[$];
   int                    errors = 0;

   function automatic void age_used_slots();
      for (int i = 0; i < ENTRIES; i++)
         if (slot_used[i]) slot_rank[i]++;
   endfunction

   function automatic lkvc_rsp_type serve_request(lkvc_req_type rq);
      lkvc_rsp_type r;
      int found, free_idx, lru_idx, limit, rank;
      r        = '0;
      found    = -1;
      free_idx = -1;
      lru_idx  = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (slot_used[i]) begin
            if (slot_tag[i] == rq.lookup_key && found < 0) found = i;
            if (lru_idx < 0 || slot_rank[i] > slot_rank[lru_idx]) lru_idx = i;
         end else if (free_idx < 0) begin
            free_idx = i;
         end
      end
      if (found >= 0) begin
         r.hit = 1'b1;
         rank  = slot_rank[found];
         for (int i = 0; i < ENTRIES; i++)
            if (slot_used[i] && i != found && slot_rank[i] < rank) slot_rank[i]++;
         slot_rank[found] = 0;
         if (rq.req_type == REQ_PUT) slot_handle[found] = rq.put_value;
         else r.read_value = slot_handle[found];
         return r;
      end
      if (rq.req_type == REQ_GET) return r;
      // zero acts as one, anything past the array acts as full size
      limit = (cap_setting == 0) ? 1 : (cap_setting > ENTRIES) ? ENTRIES : int'(cap_setting);
      if (fill_level < limit && free_idx >= 0) begin
         age_used_slots();
         slot_used[free_idx]   = 1'b1;
         slot_tag[free_idx]    = rq.lookup_key;
         slot_handle[free_idx] = rq.put_value;
         slot_rank[free_idx]   = 0;
         fill_level++;
         return r;
      end
      if (lru_idx >= 0) begin
         r.evicted            = 1'b1;
         r.evicted_key        = slot_tag[lru_idx];
         r.evicted_value      = slot_handle[lru_idx];
         slot_used[lru_idx]   = 1'b0;
         age_used_slots();
         slot_used[lru_idx]   = 1'b1;
         slot_tag[lru_idx]    = rq.lookup_key;
         slot_handle[lru_idx] = rq.put_value;
         slot_rank[lru_idx]   = 0;
      end
      return r;
   endfunction

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= 10)
            $display("%t mismatch on %s: expected %h, got %h", $realtime, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      lkvc_rsp_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            slot_used[i]   = 1'b0;
            slot_tag[i]    = '0;
            slot_handle[i] = '0;
            slot_rank[i]   = 0;
         end
         fill_level  = 0;
         cap_setting = CSR_CAP_RESET;
         lookup_results.delete();
      end else begin
         if (csr_write_enable) cap_setting = csr_write_data;
         if (req_valid && !req_stall) lookup_results.push_back(serve_request(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (lookup_results.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%t response word with nothing expected: %h", $realtime, rsp_data);
            end else begin
               want = lookup_results.pop_front();
               check_field("hit", 32'(want.hit), 32'(rsp_data.hit));
               check_field("read_value", want.read_value, rsp_data.read_value);
               check_field("evicted", 32'(want.evicted), 32'(rsp_data.evicted));
               check_field("evicted_key", want.evicted_key, rsp_data.evicted_key);
               check_field("evicted_value", want.evicted_value, rsp_data.evicted_value);
            end
         end
      end
      fail_count    <= errors;
      pending_count <= lookup_results.size();
   end

endmodule

[bench/lru_key_value_cache_tb.sv]
// ----------------------------------------------------------------------------
// lru_key_value_cache_tb
// Drives directed and random get/put words through the LRU key/value cache
// under several capacity settings, with random gaps and stalls on both
// channels, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lkvc_pkg::*;

   localparam int ENTRIES     = 16;
   localparam int PHASE_WORDS = 250;
   localparam int QUIET_LIMIT = 1000;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_stall;
   lkvc_req_type        req_data         = '0;
   logic                rsp_valid;
   logic                rsp_stall        = 1'b1;
   lkvc_rsp_type        rsp_data;
   logic                csr_write_enable = 1'b0;
   logic [CSR_BITS-1:0] csr_write_data   = '0;
   int                  fail_count;
   int                  pending_count;

   bit send_idle = 1'b1;
   bit rsp_idle  = 1'b1;
   bit hold_long = 1'b0;
   int quiet_cycles = 0;

   always #1 clock = ~clock;

   lru_key_value_cache #(.ENTRIES(ENTRIES)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   lru_key_value_cache_checker #(.ENTRIES(ENTRIES)) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   function automatic lkvc_req_type make_word(logic kind, logic [KEY_BITS-1:0] k,
                                              logic [VALUE_BITS-1:0] v);
      lkvc_req_type w;
      w.req_type   = kind;
      w.lookup_key = k;
      w.put_value  = v;
      return w;
   endfunction

   task automatic send_word(lkvc_req_type w);
      int gap;
      gap = send_idle ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic write_capacity(logic [CSR_BITS-1:0] cap);
      drain();
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= cap;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // response side: random stall per word, one long hold-off on request
   initial begin
      int hold_len;
      int served;
      served = 0;
      forever begin
         if (hold_long) begin
            hold_len  = 300;
            hold_long = 1'b0;
         end else begin
            hold_len = rsp_idle ? $urandom_range(0, 11) : 0;
         end
         if (hold_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_len) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         served++;
         if (served % 64 == 0) rsp_idle = ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [CSR_BITS-1:0] cap_plan [8];
      logic [KEY_BITS-1:0] key_base;
      logic [KEY_BITS-1:0] k;
      logic [CSR_BITS-1:0] cap;
      int                  eff, pool;
      cap_plan = '{5'd1, 5'd31, 5'd16, 5'd5, 5'd0, 5'd17, 5'd8, 5'd0};
      key_base = $urandom;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, hits, misses, update, fill, eviction
      send_word(make_word(REQ_PUT, '0, '0));
      send_word(make_word(REQ_PUT, '1, '1));
      send_word(make_word(REQ_GET, '0, '1));
      send_word(make_word(REQ_GET, '1, '0));
      send_word(make_word(REQ_GET, 32'h5A5A_5A5A, $urandom));
      send_word(make_word(REQ_GET, 32'h5A5A_5A5A, $urandom));
      send_word(make_word(REQ_PUT, '0, 32'h0000_1234));
      send_word(make_word(REQ_GET, '0, '0));
      for (int i = 0; i < ENTRIES - 2; i++)
         send_word(make_word(REQ_PUT, 32'h100 + i, $urandom));
      send_word(make_word(REQ_PUT, 32'h200, $urandom));
      // capacity below current fill
      write_capacity(5'd3);
      send_word(make_word(REQ_PUT, 32'h201, $urandom));
      send_word(make_word(REQ_GET, 32'h201, '0));
      // zero capacity behaves as one
      write_capacity(5'd0);
      send_word(make_word(REQ_PUT, 32'h202, $urandom));

      for (int p = 0; p < 8; p++) begin
         cap = (p == 7) ? 5'($urandom_range(0, 31)) : cap_plan[p];
         write_capacity(cap);
         eff  = (cap == 0) ? 1 : (cap > ENTRIES) ? ENTRIES : int'(cap);
         pool = eff + $urandom_range(1, 6);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (n % 50 == 0) send_idle = ($urandom_range(0, 3) != 0);
            if (p == 2 && n == 60) hold_long = 1'b1;
            if (p == 3 && n == 120) drain();
            if ($urandom_range(0, 9) == 0) k = $urandom;
            else k = key_base + $urandom_range(0, pool - 1);
            send_word(make_word(1'($urandom_range(0, 1)), k, $urandom));
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
